### rtl/slmc_pkg.sv
// ----------------------------------------------------------------------------
// slmc_pkg
// Shared constants, command codes and word types of the sorted list matcher.
// ----------------------------------------------------------------------------
package slmc_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int LIST_DEPTH  = 256;
  localparam int ID_BITS     = 13;

  // fixed port field widths
  localparam int FRM_W     = 6;
  localparam int LEN_OUT_W = 9;
  localparam int ID_IN_W   = 13;

  localparam int FRM_AW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int ST_AW      = FRM_AW + IDX_W;
  localparam int META_W     = LEN_W + ID_BITS;
  localparam int META_DEPTH = 2 ** FRM_AW;
  localparam int CUR_DEPTH  = 2 ** IDX_W;
  localparam int ST_DEPTH   = 2 ** ST_AW;

  localparam logic [FRM_AW-1:0] LAST_FRAME = FRM_AW'(FRAME_COUNT - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(LIST_DEPTH);

  typedef enum logic [1:0] {
    CMD_APPEND_STORED  = 2'd0,
    CMD_APPEND_CURRENT = 2'd1,
    CMD_RUN            = 2'd2,
    CMD_CLEAR          = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                command;
    logic [FRM_W-1:0]    frame_index;
    logic [ID_IN_W-1:0]  feature_id;
  } in_word_t;

  typedef struct packed {
    logic [FRM_W-1:0]     frame_number;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [LEN_OUT_W-1:0] match_count;
    logic                 load_error;
    logic                 last;
  } out_word_t;

  // list memory write requests from the loader
  typedef struct packed {
    logic               st_we;
    logic [ST_AW-1:0]   st_addr;
    logic               cur_we;
    logic [IDX_W-1:0]   cur_addr;
    logic [ID_BITS-1:0] data;
  } lst_wr_t;

  // loader status seen by the matcher
  typedef struct packed {
    logic             run_start;
    logic [LEN_W-1:0] cur_len;
    logic             load_error;
    logic [LEN_W-1:0] rd_len;
  } ld_stat_t;

  // matcher request to the loader's length memory
  typedef struct packed {
    logic              busy;
    logic              rd_en;
    logic [FRM_AW-1:0] rd_addr;
  } mt_req_t;

endpackage

### rtl/slmc_ram.sv
// ----------------------------------------------------------------------------
// slmc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/slmc_loader.sv
// ----------------------------------------------------------------------------
// slmc_loader
// Input stage: one command word a cycle unless a run stalls it; keeps list
// lengths and last ids, checks ordering and capacity, writes the list memories.
// ----------------------------------------------------------------------------
module slmc_loader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slmc_pkg::in_word_t  in_word_i,
  input  slmc_pkg::mt_req_t   mt_req_i,
  output slmc_pkg::ld_stat_t  ld_stat_o,
  output slmc_pkg::lst_wr_t   lst_wr_o
);
  import slmc_pkg::*;

  logic                  accept;
  logic                  s1_valid_q;
  cmd_e                  s1_cmd_q;
  logic [FRM_W-1:0]      s1_frame_q;
  logic [ID_BITS-1:0]    s1_id_q;
  logic [FRM_AW-1:0]     s1_faddr;

  logic [FRM_AW-1:0]     meta_raddr;
  logic [FRM_AW-1:0]     raddr_q;
  logic [META_W-1:0]     meta_rdata;
  logic [LEN_W-1:0]      ram_len;
  logic [ID_BITS-1:0]    ram_last;

  logic [META_DEPTH-1:0] valid_q, valid_d;
  logic                  fwd_valid_q, fwd_valid_d;
  logic [FRM_AW-1:0]     fwd_frame_q;
  logic [LEN_W-1:0]      fwd_len_q;
  logic [ID_BITS-1:0]    fwd_last_q;
  logic                  fwd_hit;

  logic [LEN_W-1:0]      st_len, st_len_inc;
  logic [ID_BITS-1:0]    st_last;
  logic                  in_range, st_ok, cur_ok;
  logic                  st_we, cur_we;

  logic [LEN_W-1:0]      cur_len_q, cur_len_d;
  logic [ID_BITS-1:0]    cur_last_q, cur_last_d;
  logic                  err_q, err_d;

  assign in_ready_o = !mt_req_i.busy && !(s1_valid_q && (s1_cmd_q == CMD_RUN));
  assign accept     = in_valid_i && in_ready_o;
  assign s1_faddr   = s1_frame_q[FRM_AW-1:0];

  // length / last id memory, shared read port with the matcher
  assign meta_raddr = mt_req_i.rd_en ? mt_req_i.rd_addr
                                     : in_word_i.frame_index[FRM_AW-1:0];

  slmc_ram #(
    .WIDTH (META_W),
    .DEPTH (META_DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_faddr),
    .wdata_i ({st_len_inc, s1_id_q}),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  assign ram_len  = meta_rdata[META_W-1:ID_BITS];
  assign ram_last = meta_rdata[ID_BITS-1:0];

  // previous cycle's write is not yet visible on the read port
  assign fwd_hit    = fwd_valid_q && (fwd_frame_q == s1_faddr);
  assign st_len     = fwd_hit ? fwd_len_q : (valid_q[raddr_q] ? ram_len : '0);
  assign st_last    = fwd_hit ? fwd_last_q : ram_last;
  assign st_len_inc = st_len + LEN_W'(1);

  assign in_range = {1'b0, s1_frame_q} < (FRM_W + 1)'(FRAME_COUNT);
  assign st_ok    = in_range && (st_len < LEN_MAX) &&
                    ((st_len == '0) || (s1_id_q > st_last));
  assign cur_ok   = (cur_len_q < LEN_MAX) &&
                    ((cur_len_q == '0) || (s1_id_q > cur_last_q));

  always_comb begin
    st_we       = 1'b0;
    cur_we      = 1'b0;
    valid_d     = valid_q;
    fwd_valid_d = 1'b0;
    cur_len_d   = cur_len_q;
    cur_last_d  = cur_last_q;
    err_d       = err_q;
    if (s1_valid_q) begin
      case (s1_cmd_q)
        CMD_APPEND_STORED: begin
          if (st_ok) begin
            st_we             = 1'b1;
            valid_d[s1_faddr] = 1'b1;
            fwd_valid_d       = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        CMD_APPEND_CURRENT: begin
          if (cur_ok) begin
            cur_we     = 1'b1;
            cur_len_d  = cur_len_q + LEN_W'(1);
            cur_last_d = s1_id_q;
          end else begin
            err_d = 1'b1;
          end
        end
        CMD_CLEAR: begin
          valid_d   = '0;
          cur_len_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
      cur_len_q   <= '0;
      err_q       <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      valid_q     <= valid_d;
      fwd_valid_q <= fwd_valid_d;
      cur_len_q   <= cur_len_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q    <= meta_raddr;
    cur_last_q <= cur_last_d;
    if (accept) begin
      s1_cmd_q   <= in_word_i.command;
      s1_frame_q <= in_word_i.frame_index;
      s1_id_q    <= ID_BITS'(in_word_i.feature_id);
    end
    if (st_we) begin
      fwd_frame_q <= s1_faddr;
      fwd_len_q   <= st_len_inc;
      fwd_last_q  <= s1_id_q;
    end
  end

  assign lst_wr_o.st_we    = st_we;
  assign lst_wr_o.st_addr  = {s1_faddr, st_len[IDX_W-1:0]};
  assign lst_wr_o.cur_we   = cur_we;
  assign lst_wr_o.cur_addr = cur_len_q[IDX_W-1:0];
  assign lst_wr_o.data     = s1_id_q;

  assign ld_stat_o.run_start  = s1_valid_q && (s1_cmd_q == CMD_RUN);
  assign ld_stat_o.cur_len    = cur_len_q;
  assign ld_stat_o.load_error = err_q;
  assign ld_stat_o.rd_len     = valid_q[raddr_q] ? ram_len : '0;

  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lst_wr_o.st_we || lst_wr_o.cur_we) |-> !mt_req_i.busy)
    else $error("list write during a run");

  a_cur_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= LEN_MAX)
    else $error("current length beyond depth");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag dropped");

endmodule

### rtl/slmc_matcher.sv
// ----------------------------------------------------------------------------
// slmc_matcher
// Run sequencer: per stored frame, fetches its length, merge-walks both lists
// one step a cycle and hands each count to the output register.
// ----------------------------------------------------------------------------
module slmc_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slmc_pkg::ld_stat_t          ld_stat_i,
  output slmc_pkg::mt_req_t           mt_req_o,
  output logic [slmc_pkg::ST_AW-1:0]  st_raddr_o,
  output logic [slmc_pkg::IDX_W-1:0]  cur_raddr_o,
  input  logic [slmc_pkg::ID_BITS-1:0] st_rdata_i,
  input  logic [slmc_pkg::ID_BITS-1:0] cur_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output slmc_pkg::out_word_t         out_word_o
);
  import slmc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_META = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FRM_AW-1:0] f_q, f_d;
  logic [LEN_W-1:0]  i_q, i_d, j_q, j_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  hits_q, hits_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q;
  logic              out_load;
  logic              out_free;
  logic              more;

  assign out_free = !out_valid_q || out_ready_i;
  assign more     = (i_q < len_q) && (j_q < ld_stat_i.cur_len);

  always_comb begin
    state_d     = state_q;
    f_d         = f_q;
    i_d         = i_q;
    j_d         = j_q;
    len_d       = len_q;
    hits_d      = hits_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (ld_stat_i.run_start) begin
          state_d = ST_META;
          f_d     = '0;
          i_d     = '0;
          j_d     = '0;
          hits_d  = '0;
        end
      end
      ST_META: begin
        len_d   = ld_stat_i.rd_len;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (more) begin
          if (st_rdata_i == cur_rdata_i) begin
            hits_d = hits_q + LEN_W'(1);
            i_d    = i_q + LEN_W'(1);
            j_d    = j_q + LEN_W'(1);
          end else if (st_rdata_i < cur_rdata_i) begin
            i_d = i_q + LEN_W'(1);
          end else begin
            j_d = j_q + LEN_W'(1);
          end
        end else if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (f_q == LAST_FRAME) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_META;
            f_d     = f_q + FRM_AW'(1);
            i_d     = '0;
            j_d     = '0;
            hits_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    i_q    <= i_d;
    j_q    <= j_d;
    len_q  <= len_d;
    hits_q <= hits_d;
    if (out_load) begin
      out_q.frame_number <= FRM_W'(f_q);
      out_q.frame_length <= LEN_OUT_W'(len_q);
      out_q.match_count  <= LEN_OUT_W'(hits_q);
      out_q.load_error   <= ld_stat_i.load_error;
      out_q.last         <= (f_q == LAST_FRAME);
    end
  end

  // read addresses follow the next pointers so data lines up with i_q / j_q
  assign st_raddr_o  = {f_d, i_d[IDX_W-1:0]};
  assign cur_raddr_o = j_d[IDX_W-1:0];

  assign mt_req_o.busy    = (state_q != ST_IDLE);
  assign mt_req_o.rd_en   = (state_d != ST_IDLE);
  assign mt_req_o.rd_addr = f_d;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((hits_q <= i_q) && (hits_q <= j_q)))
    else $error("match count exceeds pointers");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((i_q <= len_q) && (j_q <= ld_stat_i.cur_len)))
    else $error("walk pointer past list end");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && ld_stat_i.run_start) |=>
      ((state_q == ST_META) && (f_q == '0)))
    else $error("run did not start at frame zero");

endmodule

### rtl/sorted_list_match_counter_top.sv
// ----------------------------------------------------------------------------
// sorted_list_match_counter_top
// Sorted feature list matcher: loads stored and current id lists, then
// counts shared ids of the current list against every stored frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_word_i): one command word per
// cycle. Appends and clears are taken back to back and give no result; they
// complete from a registered input stage. A run word stops the input until
// its last result has been loaded into the output register.
// Output channel (out_valid_o / out_ready_i / out_word_o): one word per
// stored frame, in frame order, last flagged on the final frame.
// Run sequence: per frame, ST_META fetches the length and ST_WALK takes s
// merge steps (at most len_f + current length), one step a cycle, set by the
// single read port of each list memory, then loads the result. The first
// result follows the run word, ST_META and the merge steps of frame 0.
// A stalled receiver holds the word in the output register; the walk of the
// next frame proceeds and waits with its result until the register frees.
// Reset clears the current length, the error flag and, at once through
// per-frame valid bits, the list lengths; list contents need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_match_counter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slmc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slmc_pkg::out_word_t out_word_o
);
  import slmc_pkg::*;

  mt_req_t            mt_req;
  ld_stat_t           ld_stat;
  lst_wr_t            lst_wr;
  logic [ST_AW-1:0]   st_raddr;
  logic [IDX_W-1:0]   cur_raddr;
  logic [ID_BITS-1:0] st_rdata;
  logic [ID_BITS-1:0] cur_rdata;

  slmc_loader u_loader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .mt_req_i   (mt_req),
    .ld_stat_o  (ld_stat),
    .lst_wr_o   (lst_wr)
  );

  slmc_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (ST_DEPTH)
  ) u_stored_ram (
    .clk_i   (clk_i),
    .we_i    (lst_wr.st_we),
    .waddr_i (lst_wr.st_addr),
    .wdata_i (lst_wr.data),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  slmc_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (CUR_DEPTH)
  ) u_current_ram (
    .clk_i   (clk_i),
    .we_i    (lst_wr.cur_we),
    .waddr_i (lst_wr.cur_addr),
    .wdata_i (lst_wr.data),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  slmc_matcher u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_stat_i   (ld_stat),
    .mt_req_o    (mt_req),
    .st_raddr_o  (st_raddr),
    .cur_raddr_o (cur_raddr),
    .st_rdata_i  (st_rdata),
    .cur_rdata_i (cur_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
